// ===== hw/rtl/gdsr_pkg.sv =====
// Package: shared constants and a helper for the GDSII real converter.
package gdsr_pkg;
  localparam int unsigned WordW = 64;
  localparam int unsigned FracW = 56;
  localparam int unsigned PosW  = 6;
  localparam int unsigned ExpW  = 11;
  localparam int unsigned Bias  = 1023;
  localparam int unsigned ExpOffset = 312;

  // Priority search for the highest set bit in a nonzero 56-bit fraction.
  function automatic logic [PosW-1:0] top_bit(input logic [FracW-1:0] v);
    logic [PosW-1:0] p;
    p = '0;
    for (int i = 0; i < FracW; i++) begin
      if (v[i]) begin
        p = PosW'(i);
      end
    end
    return p;
  endfunction
endpackage

// ===== hw/rtl/gdsii_real_to_ieee_double_core.sv =====
// Top level: pipelined GDSII eight-byte real to IEEE 754 double converter.
//
// Channels: the slave side (s_axis_*) takes one GDSII real per request in
// tdata, first stream byte in bits 63..56. The master side (m_axis_*)
// returns the IEEE 754 binary64 pattern of the same value in tdata.
// One result leaves for every request taken, in order.
// Pipeline: stage 1 splits fields and finds the leading one, stage 2
// normalizes the fraction and forms the exponent, stage 3 rounds to nearest
// even and packs the result into the output register.
// A request passes the stage 1, 2 and 3 registers in order. Throughput: one
// request per cycle unless the output stalls, set by the three stages each
// taking a new request whenever the stage after it moves or is empty.
// Reset: rst clears all valid bits; payload registers keep stale data.
// Stall: when m_axis_tready is low the output holds; earlier stages keep
// filling until they meet an occupied stage, then s_axis_tready drops.
// Nothing is lost or repeated.
module gdsii_real_to_ieee_double_core
  import gdsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [WordW-1:0] s_axis_tdata,  // [63:0] raw_word
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [WordW-1:0] m_axis_tdata   // [63:0] ieee_bits
);
  // Stage 1 registers: split fields, leading-one position.
  logic             v1;
  logic             sgn1, zero1;
  logic [6:0]       ex1;
  logic [FracW-1:0] frac1;
  logic [PosW-1:0]  p1;
  // Stage 2 registers: normalized fraction (leading one at bit 55).
  logic             v2;
  logic             sgn2, zero2;
  logic [ExpW-1:0]  be2;
  logic [FracW-1:0] norm2;
  // Stage 3: output register.
  logic             v3;
  logic [WordW-1:0] out3;

  logic adv1, adv2, adv3;
  assign adv3 = !v3 || m_axis_tready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign s_axis_tready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= s_axis_tvalid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // Stage 1: take the request apart and locate the leading one.
  always_ff @(posedge clk) begin
    if (adv1 && s_axis_tvalid) begin
      sgn1  <= s_axis_tdata[63];
      ex1   <= s_axis_tdata[62:56];
      frac1 <= s_axis_tdata[FracW-1:0];
      zero1 <= (s_axis_tdata[FracW-1:0] == '0);
      p1    <= top_bit(s_axis_tdata[FracW-1:0]);
    end
  end

  // Stage 2: shift the leading one to bit 55; biased exponent for it there.
  // Value = norm * 2^(4e - 312 + p - 55); IEEE exponent taken at bit 55 is
  // p + 4e - 312 + 1023, always in 711..1274 before the rounding carry.
  logic [PosW-1:0] lsh;
  logic [ExpW-1:0] be_calc;
  assign lsh = PosW'(FracW - 1) - p1;
  assign be_calc = ExpW'({ex1, 2'b00}) + ExpW'(p1) + ExpW'(Bias) - ExpW'(ExpOffset);

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      sgn2  <= sgn1;
      zero2 <= zero1;
      norm2 <= frac1 << lsh;
      be2   <= be_calc;
    end
  end

  // Stage 3: drop three bits with round to nearest even, then pack.
  logic [53:0]     rmant;
  logic            rup;
  logic [ExpW-1:0] be_fin;
  logic [51:0]     mfin;
  always_comb begin
    rup    = norm2[2] && (norm2[1] || norm2[0] || norm2[3]);
    rmant  = {1'b0, norm2[55:3]} + 54'(rup);
    if (rmant[53]) begin
      be_fin = be2 + ExpW'(1);
      mfin   = rmant[52:1];
    end else begin
      be_fin = be2;
      mfin   = rmant[51:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      if (zero2) begin
        out3 <= {sgn2, 63'd0};
      end else begin
        out3 <= {sgn2, be_fin, mfin};
      end
    end
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = out3;

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output changed under stall");
  a_norm: assert property (@(posedge clk) disable iff (rst)
    (v2 && !zero2) |-> norm2[FracW-1])
    else $error("fraction not normalized");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && !m_axis_tready) |-> !s_axis_tready)
    else $error("ready high with full pipe");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> v1)
    else $error("accepted request lost");
`endif
endmodule

// ===== test/tb.sv =====
// Testbench for the GDSII eight-byte real to IEEE double converter.
module tb;
  import gdsr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [WordW-1:0] s_axis_tdata;  // [63:0] raw_word
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [WordW-1:0] m_axis_tdata;  // [63:0] ieee_bits

  logic [63:0] expected_doubles[$];
  int          error_count;
  int          cycle_count;
  int          requests_sent;
  int          results_seen;
  bit          no_stall;  // hold both sides busy-free during a stretch

  gdsii_real_to_ieee_double_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Convert one GDSII real: value = f * 2^(4e - 312), rounded to 53 bits.
  function automatic logic [63:0] gds_to_double(input logic [63:0] word);
    logic        sgn;
    logic [6:0]  ex;
    logic [55:0] frac;
    logic [55:0] rem;
    logic [55:0] half;
    logic [53:0] mant;
    int          msb;
    int          sh;
    int          e2;
    sgn  = word[63];
    ex   = word[62:56];
    frac = word[55:0];
    if (frac == '0) return {sgn, 63'd0};
    msb = 0;
    for (int i = 0; i < 56; i++) if (frac[i]) msb = i;
    e2 = msb + 4 * int'(ex) - 312;
    if (msb > 52) begin
      sh   = msb - 52;
      rem  = frac & ((56'd1 << sh) - 56'd1);
      half = 56'd1 << (sh - 1);
      mant = 54'(frac >> sh);
      if (rem > half || (rem == half && mant[0])) mant = mant + 54'd1;
      if (mant[53]) begin
        mant = mant >> 1;
        e2++;
      end
    end else begin
      mant = 54'(frac << (52 - msb));
    end
    return {sgn, 11'(e2 + 1023), mant[51:0]};
  endfunction

  // Drive one request; the prediction is queued when the handshake completes.
  // Valid stays high after the handshake so the next request can follow
  // directly; idling or draining drops it.
  task automatic send_word(input logic [63:0] word);
    while (!no_stall && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_doubles.push_back(gds_to_double(word));
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_doubles.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    logic [63:0] words[$];
    words = '{64'h0, 64'h8000_0000_0000_0000, 64'h7F00_0000_0000_0000,
              64'hFF00_0000_0000_0000, 64'h4110_0000_0000_0000,
              64'hC110_0000_0000_0000, 64'h0000_0000_0000_0001,
              64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              64'h0080_0000_0000_0000, 64'h7F80_0000_0000_0000,
              64'h4080_0000_0000_0004,   // tie, even: stays
              64'h4080_0000_0000_000C,   // tie, odd: rounds up
              64'h4080_0000_0000_0005,   // above half
              64'h40FF_FFFF_FFFF_FFF8,   // dropped bits zero: exact, no carry
              64'h4010_0000_0000_0001,   // no rounding (msb 52)
              64'h4020_0000_0000_0001,   // one bit dropped, tie
              64'h4040_0000_0000_0003,   // two bits dropped
              64'h0000_0000_0000_0080, 64'hAA55_AA55_AA55_AA55};
    foreach (words[i]) send_word(words[i]);
  endtask

  // Random words; one in four gets a narrowed fraction, one in four near-tie low bits.
  task automatic test_random(input int count);
    logic [63:0] w;
    for (int i = 0; i < count; i++) begin
      w = random_word();
      case ($urandom_range(3))
        0: w[55:0] = w[55:0] >> $urandom_range(55);
        1: w[2:0]  = 3'($urandom_range(1) ? 3'b100 : 3'b011);
        default: ;
      endcase
      send_word(w);
    end
  endtask

  task automatic test_backpressure_pause();
    test_random(50);
    wait_drained();  // sender holds off until every result is back
    test_random(50);
  endtask

  task automatic test_no_idle();
    no_stall = 1'b1;
    test_random(200);
    no_stall = 1'b0;
  endtask

  // Random sink stalls.
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= no_stall || ($urandom_range(99) >= 14);
  end

  always @(posedge clk) begin
    logic [63:0] exp_val;
    cycle_count <= cycle_count + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_doubles.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        exp_val = expected_doubles.pop_front();
        if (m_axis_tdata !== exp_val) begin
          $display("%0t: ieee_bits mismatch expected %h actual %h",
                   $time, exp_val, m_axis_tdata);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > 200000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("gdsii_real_to_ieee_double_core regression: fail");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    requests_sent = 0;
    no_stall = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(580);
    test_backpressure_pause();
    test_no_idle();
    wait_drained();
    $display("covered %0d conversions, %0d results checked, incl. zeros, ties, carries",
             requests_sent, results_seen);
    if (error_count == 0 && expected_doubles.size() == 0) begin
      $display("gdsii_real_to_ieee_double_core regression: pass");
    end else begin
      $display("gdsii_real_to_ieee_double_core regression: fail");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/gdsr_pkg.sv
hw/rtl/gdsii_real_to_ieee_double_core.sv
test/tb.sv
